[rtl/core/scfa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scfa_pkg
// Shared field widths and codes of the size-class free-list allocator core.
// ----------------------------------------------------------------------------
package scfa_pkg;

    localparam int REQ_W    = 16;
    localparam int HANDLE_W = 10;
    localparam int SIZE_W   = 17;
    localparam int STATUS_W = 2;

    // Operation carried in the input tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GRANT    = 2'd0,
        STATUS_SYSALLOC = 2'd1,
        STATUS_POOLED   = 2'd2,
        STATUS_RELEASED = 2'd3
    } status_t;

endpackage
`default_nettype wire

[rtl/core/size_class_free_list_allocator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_core
// Pool manager with one LIFO free list per size class, kept in two RAMs.
// ----------------------------------------------------------------------------
// Usage: each input transaction is an allocate (s_tuser = 0) or a free
// (s_tuser = 1); each produces exactly one result transaction on the m_ side,
// in order. Allocate rounds the size up to ALIGN_BYTES and, within the pool
// limit, pops a handle from its class list if one is there; free pushes the
// handle onto its class list within the pool limit, else releases the block.
// The list heads sit in a head RAM (handle) plus per-class valid flops, the
// links in a link RAM indexed by handle.
// A free or a miss goes from ST_HEAD to the output register; a pool grant
// also passes ST_LINK, since the pop reads the head and then its link.
// The next transaction is taken in the cycle that writes back the previous
// one; a head write to the same class is forwarded to the new read.
// Reset clears all class valid flags, so every list starts empty; link RAM
// contents need no initialization. If the receiver stalls, one result waits
// in the output register and the core holds its current transaction, which
// in turn holds off s_tready.
// ALIGN_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_core #(
    parameter int ALIGN_BYTES = 16,
    parameter int CLASS_LIMIT = 64,
    parameter int BLOCK_COUNT = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] request_size, [25:16] block_handle, [42:26] block_size
    input  wire logic [47:0] s_tdata,
    // [0] operation
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [9:0] grant_handle, [26:10] rounded_size
    output logic      [31:0] m_tdata,
    // [1:0] status
    output logic      [1:0]  m_tuser
);

    localparam int HW          = scfa_pkg::HANDLE_W;
    localparam int SW          = scfa_pkg::SIZE_W;
    localparam int CLASS_COUNT = CLASS_LIMIT + 1;
    localparam int CLS_W       = $clog2(CLASS_COUNT);
    localparam int LINK_AW     = $clog2(BLOCK_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HEAD = 3'b010,
        ST_LINK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Input fields.
    logic [scfa_pkg::REQ_W-1:0] in_req;
    logic [HW-1:0]              in_handle;
    logic [SW-1:0]              in_bsize;
    logic                       in_op;
    logic [SW-1:0]              dec_rsize;
    logic [CLS_W-1:0]           dec_cls;
    logic                       dec_in_pool;

    assign in_req    = s_tdata[15:0];
    assign in_handle = s_tdata[25:16];
    assign in_bsize  = s_tdata[42:26];
    assign in_op     = s_tuser[0];

    scfa_size_decode #(
        .ALIGN_BYTES (ALIGN_BYTES),
        .CLASS_LIMIT (CLASS_LIMIT)
    ) u_decode (
        .op           (in_op),
        .request_size (in_req),
        .block_size   (in_bsize),
        .rounded_size (dec_rsize),
        .size_class   (dec_cls),
        .in_pool      (dec_in_pool)
    );

    // Transaction registers.
    logic             op_reg;
    logic [CLS_W-1:0] cls_reg;
    logic             in_pool_reg;
    logic [SW-1:0]    rsize_reg;
    logic [HW-1:0]    handle_reg;
    logic             fwd_reg;
    logic [HW-1:0]    fwd_handle_reg;
    logic [HW-1:0]    grant_reg;
    logic             link_ok_reg;

    // Class valid flags.
    logic [CLASS_COUNT-1:0] head_valid_reg, head_valid_next;

    // Output register.
    logic                  m_valid_reg;
    scfa_pkg::status_t     m_status_reg;
    logic [HW-1:0]         m_grant_reg;
    logic [SW-1:0]         m_rsize_reg;

    // RAM ports.
    logic               head_we;
    logic [CLS_W-1:0]   head_waddr;
    logic [HW-1:0]      head_wdata;
    logic               head_re;
    logic [HW-1:0]      head_rdata;
    logic               link_we;
    logic [LINK_AW-1:0] link_waddr;
    logic [HW:0]        link_wdata;
    logic               link_re;
    logic [LINK_AW-1:0] link_raddr;
    logic [HW:0]        link_rdata;

    scfa_ram #(
        .WIDTH (HW),
        .DEPTH (CLASS_COUNT)
    ) u_head_ram (
        .aclk    (aclk),
        .wr_en   (head_we),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_en   (head_re),
        .rd_addr (dec_cls),
        .rd_data (head_rdata)
    );

    scfa_ram #(
        .WIDTH (HW + 1),
        .DEPTH (BLOCK_COUNT)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_en   (link_re),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    logic              out_free;
    logic              finish;
    logic              accept;
    logic              cur_head_valid;
    logic [HW-1:0]     cur_head;
    logic              pop_hit;
    logic [31:0]       cur_head_wide;
    logic [31:0]       handle_wide;
    logic              handle_ok;
    logic              head_ok;
    scfa_pkg::status_t res_status;
    logic [HW-1:0]     res_grant;

    assign out_free       = !m_valid_reg || m_tready;
    assign cur_head_valid = head_valid_reg[cls_reg];
    assign cur_head       = fwd_reg ? fwd_handle_reg : head_rdata;
    assign pop_hit        = (op_reg == scfa_pkg::OP_ALLOC) && in_pool_reg && cur_head_valid;
    assign cur_head_wide  = 32'(cur_head);
    assign handle_wide    = 32'(handle_reg);
    assign handle_ok      = handle_wide < 32'(BLOCK_COUNT);
    assign head_ok        = cur_head_wide < 32'(BLOCK_COUNT);

    always_comb begin
        finish = 1'b0;
        unique case (state_reg)
            ST_IDLE: finish = 1'b0;
            ST_HEAD: finish = !pop_hit && out_free;
            ST_LINK: finish = out_free;
            default: finish = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) || finish;
    assign accept   = s_tvalid && s_tready;
    assign head_re  = accept;

    always_comb begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        head_we         = 1'b0;
        head_waddr      = cls_reg;
        head_wdata      = handle_reg;
        link_we         = 1'b0;
        link_waddr      = handle_wide[LINK_AW-1:0];
        link_wdata      = {cur_head_valid, cur_head};
        link_re         = 1'b0;
        link_raddr      = cur_head_wide[LINK_AW-1:0];
        res_status      = scfa_pkg::STATUS_SYSALLOC;
        res_grant       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                state_next = ST_IDLE;
            end
            ST_HEAD: begin
                if (pop_hit) begin
                    // Fetch the link of the head handle; ST_LINK writes it back.
                    link_re    = head_ok;
                    state_next = ST_LINK;
                end else if (op_reg == scfa_pkg::OP_ALLOC) begin
                    res_status = scfa_pkg::STATUS_SYSALLOC;
                end else if (!in_pool_reg) begin
                    res_status = scfa_pkg::STATUS_RELEASED;
                end else begin
                    res_status = scfa_pkg::STATUS_POOLED;
                    if (finish && handle_ok) begin
                        link_we                  = 1'b1;
                        head_we                  = 1'b1;
                        head_valid_next[cls_reg] = 1'b1;
                    end
                end
            end
            ST_LINK: begin
                res_status = scfa_pkg::STATUS_GRANT;
                res_grant  = grant_reg;
                head_wdata = link_rdata[HW-1:0];
                if (finish) begin
                    head_we                  = link_ok_reg;
                    head_valid_next[cls_reg] = link_ok_reg && link_rdata[HW];
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (finish) begin
            state_next = ST_IDLE;
        end
        if (accept) begin
            state_next = ST_HEAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= in_op;
            cls_reg        <= dec_cls;
            in_pool_reg    <= dec_in_pool;
            rsize_reg      <= dec_rsize;
            handle_reg     <= in_handle;
            // The head RAM returns the old entry when it is written this cycle.
            fwd_reg        <= head_we && (head_waddr == dec_cls);
            fwd_handle_reg <= head_wdata;
        end
        if (state_reg == ST_HEAD && pop_hit) begin
            grant_reg   <= cur_head;
            link_ok_reg <= head_ok;
        end
        if (finish) begin
            m_status_reg <= res_status;
            m_grant_reg  <= res_grant;
            m_rsize_reg  <= rsize_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'b0, m_rsize_reg, m_grant_reg};

endmodule
`default_nettype wire

[rtl/core/scfa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[rtl/core/scfa_size_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scfa_size_decode
// Rounds the request size, picks the size class and checks the pool limit.
// ----------------------------------------------------------------------------
module scfa_size_decode #(
    parameter int ALIGN_BYTES = 16,
    parameter int CLASS_LIMIT = 64
) (
    input  wire logic                               op,
    input  wire logic [scfa_pkg::REQ_W-1:0]         request_size,
    input  wire logic [scfa_pkg::SIZE_W-1:0]        block_size,
    output logic      [scfa_pkg::SIZE_W-1:0]        rounded_size,
    output logic      [$clog2(CLASS_LIMIT+1)-1:0]   size_class,
    output logic                                    in_pool
);

    // ALIGN_BYTES is a power of two, so rounding is an add and a mask.
    localparam int SHIFT    = $clog2(ALIGN_BYTES);
    localparam int CLS_W    = $clog2(CLASS_LIMIT + 1);
    localparam int POOL_MAX = CLASS_LIMIT * ALIGN_BYTES;
    localparam logic [scfa_pkg::SIZE_W-1:0] LOW_MASK =
        scfa_pkg::SIZE_W'(ALIGN_BYTES - 1);

    logic [scfa_pkg::SIZE_W-1:0] req_sum;
    logic [scfa_pkg::SIZE_W-1:0] req_round;
    logic [scfa_pkg::SIZE_W-1:0] eff_size;
    logic [scfa_pkg::SIZE_W-1:0] shifted;

    always_comb begin
        req_sum   = scfa_pkg::SIZE_W'(request_size) + LOW_MASK;
        req_round = req_sum & ~LOW_MASK;
        eff_size  = (op == scfa_pkg::OP_ALLOC) ? req_round : block_size;
        shifted   = eff_size >> SHIFT;
    end

    assign rounded_size = eff_size;
    assign size_class   = shifted[CLS_W-1:0];
    assign in_pool      = (32'(eff_size) <= 32'(POOL_MAX));

endmodule
`default_nettype wire

[verif/size_class_free_list_allocator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_core_tb
// Self-checking bench for the size-class free-list allocator. Allocate and
// free transactions are streamed in with random gaps. A shadow copy of the
// class heads and link memory predicts each result. Results are compared in
// order while the receiver stalls at random.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_core_tb;

    localparam int ALIGN_BYTES    = 16;
    localparam int CLASS_LIMIT    = 64;
    localparam int BLOCK_COUNT    = 1024;
    localparam int CLASS_COUNT    = CLASS_LIMIT + 1;
    localparam int POOL_MAX_BYTES = CLASS_LIMIT * ALIGN_BYTES;
    localparam int RANDOM_OPS     = 1730;
    localparam int BACKPRESSURE_AT = 600;
    localparam int DRAIN_AT       = 1200;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic                          op;
        logic [scfa_pkg::REQ_W-1:0]    req;
        logic [scfa_pkg::HANDLE_W-1:0] handle;
        logic [scfa_pkg::SIZE_W-1:0]   bsize;
    } pool_op_t;

    typedef struct packed {
        scfa_pkg::status_t             status;
        logic [scfa_pkg::HANDLE_W-1:0] handle;
        logic [scfa_pkg::SIZE_W-1:0]   rsize;
    } pool_result_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic [1:0]          m_tuser;

    // Shadow copy of the free lists.
    logic                          head_valid  [0:CLASS_COUNT-1];
    logic [scfa_pkg::HANDLE_W-1:0] head_handle [0:CLASS_COUNT-1];
    logic                          link_valid  [0:BLOCK_COUNT-1];
    logic [scfa_pkg::HANDLE_W-1:0] link_handle [0:BLOCK_COUNT-1];

    pool_op_t     pending_ops[$];
    pool_result_t expected_results[$];
    pool_op_t     cur_op;
    int           accepted_cnt = 0;
    int           total_ops    = 0;
    int           mismatches   = 0;
    int           tx_gap       = 0;
    int           rx_stall     = 0;
    int           rx_hold_left = 0;
    bit           hold_done    = 1'b0;
    bit           draining     = 1'b0;

    size_class_free_list_allocator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic pool_result_t predict_pool_op(pool_op_t r);
        pool_result_t res;
        int unsigned  rounded;
        int unsigned  cls;
        res.handle = '0;
        if (r.op == scfa_pkg::OP_ALLOC) begin
            rounded    = ((int'(r.req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
            res.rsize  = scfa_pkg::SIZE_W'(rounded);
            res.status = scfa_pkg::STATUS_SYSALLOC;
            cls        = rounded / ALIGN_BYTES;
            if (rounded <= POOL_MAX_BYTES && head_valid[cls]) begin
                res.handle       = head_handle[cls];
                res.status       = scfa_pkg::STATUS_GRANT;
                head_valid[cls]  = link_valid[res.handle];
                head_handle[cls] = link_handle[res.handle];
            end
        end else begin
            res.rsize = r.bsize;
            if (r.bsize > POOL_MAX_BYTES) begin
                res.status = scfa_pkg::STATUS_RELEASED;
            end else begin
                // Sizes between multiples fall into the class below.
                cls                   = r.bsize / ALIGN_BYTES;
                res.status            = scfa_pkg::STATUS_POOLED;
                link_valid[r.handle]  = head_valid[cls];
                link_handle[r.handle] = head_handle[cls];
                head_valid[cls]       = 1'b1;
                head_handle[cls]      = r.handle;
            end
        end
        return res;
    endfunction

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit quiet_phase();
        return ((accepted_cnt / 200) % 5) == 4;
    endfunction

    // Fields that the operation does not use carry random values.
    task automatic queue_op(logic op, int req, int handle, int bsize);
        pool_op_t t;
        t.op     = op;
        t.req    = (op == scfa_pkg::OP_ALLOC) ? scfa_pkg::REQ_W'(req)
                                               : scfa_pkg::REQ_W'($urandom);
        t.handle = (op == scfa_pkg::OP_FREE) ? scfa_pkg::HANDLE_W'(handle)
                                              : scfa_pkg::HANDLE_W'($urandom);
        t.bsize  = (op == scfa_pkg::OP_FREE) ? scfa_pkg::SIZE_W'(bsize)
                                              : scfa_pkg::SIZE_W'($urandom_range(0, 65536));
        pending_ops.push_back(t);
    endtask

    task automatic report_mismatch(string field, int unsigned want, int unsigned got);
        if (mismatches < 10)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
        mismatches++;
    endtask

    // Driver: holds the current transaction until accepted, then waits out a gap.
    always @(posedge aclk) begin
        logic fire;
        logic offer;
        fire = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (fire) begin
                expected_results.push_back(predict_pool_op(cur_op));
                accepted_cnt++;
                tx_gap = (rx_hold_left > 0 || quiet_phase()) ? 0 : pick_gap();
                if (accepted_cnt == DRAIN_AT)
                    draining = 1'b1;
            end
            if (draining && expected_results.size() == 0)
                draining = 1'b0;
            offer = s_tvalid && !fire;
            if (!offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (!draining && pending_ops.size() > 0) begin
                    cur_op = pending_ops.pop_front();
                    offer  = 1'b1;
                end
            end
            s_tvalid <= offer;
            s_tdata  <= {5'b0, cur_op.bsize, cur_op.handle, cur_op.req};
            s_tuser  <= cur_op.op;
        end
    end

    // Receiver: random stalls plus one long hold-off that backs up the core.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && accepted_cnt >= BACKPRESSURE_AT) begin
                rx_hold_left = HOLD_CYCLES;
                hold_done    = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else if (!quiet_phase() && $urandom_range(0, 3) == 0) begin
                rx_stall = pick_gap();
                m_tready <= (rx_stall == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: each result transaction against the oldest prediction.
    always @(posedge aclk) begin
        pool_result_t got;
        pool_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = scfa_pkg::status_t'(m_tuser);
            got.handle = m_tdata[9:0];
            got.rsize  = m_tdata[26:10];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", 0, got.status);
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", want.status, got.status);
                if (got.handle != want.handle)
                    report_mismatch("grant_handle", want.handle, got.handle);
                if (got.rsize != want.rsize)
                    report_mismatch("rounded_size", want.rsize, got.rsize);
            end
        end
    end

    initial begin
        int cls;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            head_valid[c]  = 1'b0;
            head_handle[c] = '0;
        end
        for (int h = 0; h < BLOCK_COUNT; h++) begin
            link_valid[h]  = 1'b0;
            link_handle[h] = '0;
        end

        queue_op(scfa_pkg::OP_ALLOC, 0, 0, 0);          // zero bytes, class 0 empty
        queue_op(scfa_pkg::OP_FREE, 0, 0, 0);
        queue_op(scfa_pkg::OP_ALLOC, 0, 0, 0);          // zero bytes granted from class 0
        queue_op(scfa_pkg::OP_FREE, 0, 1023, 1024);     // top class
        queue_op(scfa_pkg::OP_ALLOC, 1009, 0, 0);
        queue_op(scfa_pkg::OP_ALLOC, 1024, 0, 0);
        queue_op(scfa_pkg::OP_ALLOC, 1025, 0, 0);       // just above the pool limit
        queue_op(scfa_pkg::OP_ALLOC, 65535, 0, 0);      // largest request, rounds up to 65536
        queue_op(scfa_pkg::OP_FREE, 0, 512, 1025);      // released to the system
        queue_op(scfa_pkg::OP_FREE, 0, 3, 65536);
        queue_op(scfa_pkg::OP_FREE, 0, 5, 17);          // odd size lands in class 1
        queue_op(scfa_pkg::OP_ALLOC, 17, 0, 0);
        queue_op(scfa_pkg::OP_ALLOC, 16, 0, 0);
        queue_op(scfa_pkg::OP_FREE, 0, 7, 1008);        // same handle freed twice
        queue_op(scfa_pkg::OP_FREE, 0, 7, 1008);
        queue_op(scfa_pkg::OP_ALLOC, 993, 0, 0);
        queue_op(scfa_pkg::OP_ALLOC, 1008, 0, 0);
        queue_op(scfa_pkg::OP_FREE, 0, 341, 32);
        queue_op(scfa_pkg::OP_FREE, 0, 682, 32);
        queue_op(scfa_pkg::OP_ALLOC, 32, 0, 0);
        queue_op(scfa_pkg::OP_ALLOC, 31, 0, 0);

        // Mostly allocate/free traffic on a few hot classes so pops hit,
        // with a fifth of fully random transactions.
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_op($urandom_range(0, 1), $urandom_range(0, 65535),
                         $urandom_range(0, 1023), $urandom_range(0, 65536));
            end else begin
                cls = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CLASS_LIMIT)
                                                  : $urandom_range(0, 6);
                if ($urandom_range(0, 1) == 1) begin
                    queue_op(scfa_pkg::OP_FREE, 0, $urandom_range(0, 1023),
                             cls * ALIGN_BYTES + ((cls < CLASS_LIMIT &&
                             $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0));
                end else begin
                    queue_op(scfa_pkg::OP_ALLOC, (cls == 0) ? 0
                             : cls * ALIGN_BYTES - $urandom_range(0, 15), 0, 0);
                end
            end
        end
        total_ops = pending_ops.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < total_ops || expected_results.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
